FILE: rtl/srrt_pkg.sv
package srrt_pkg;

  // packet layout in bytes
  localparam logic [7:0] HDR_BYTES   = 8'd3;
  localparam logic [7:0] ENTRY_BYTES = 8'd2;

  // register reset values
  localparam logic [7:0] PEER_CAP_RST = 8'd255;
  localparam logic [7:0] OWN_CAP_RST  = 8'd255;
  localparam logic [7:0] IDLE_THR_RST = 8'd100;

  // width of a per-packet entry count, up to (255 - 3) / 2
  localparam int unsigned EntW = 7;

  typedef enum logic [1:0] {
    REQ_POLL  = 2'd0,
    REQ_META  = 2'd1,
    REQ_DATA  = 2'd2,
    REQ_OTHER = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_CMPL  = 2'd1,
    KIND_MISS  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_PEER_CAP = 2'd0,
    REG_OWN_CAP  = 2'd1,
    REG_IDLE_THR = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_CLEAR,
    ST_ADV,
    ST_CMPL,
    ST_SCAN_CHK,
    ST_SCAN_EV
  } state_e;

  typedef struct packed {
    logic [7:0]      idle_thr;
    logic [EntW-1:0] pkt_entries;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] seq;
    logic [5:0]  miss;
    logic        eop;
    logic        last;
  } res_t;

endpackage

FILE: rtl/srrt_map_ram.sv
module srrt_map_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  logic mem_q [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/srrt_cfg_regs.sv
module srrt_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output srrt_pkg::cfg_t     cfg_o
);

  logic [7:0] peer_cap_q, peer_cap_d;
  logic [7:0] own_cap_q, own_cap_d;
  logic [7:0] idle_thr_q, idle_thr_d;
  logic [1:0] reg_idx;
  logic       wr_en;
  logic [7:0] cap;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    peer_cap_d = peer_cap_q;
    own_cap_d  = own_cap_q;
    idle_thr_d = idle_thr_q;
    prdata     = '0;
    case (reg_idx)
      srrt_pkg::REG_PEER_CAP: begin
        prdata = {24'd0, peer_cap_q};
        if (wr_en) peer_cap_d = pwdata[7:0];
      end
      srrt_pkg::REG_OWN_CAP: begin
        prdata = {24'd0, own_cap_q};
        if (wr_en) own_cap_d = pwdata[7:0];
      end
      srrt_pkg::REG_IDLE_THR: begin
        prdata = {24'd0, idle_thr_q};
        if (wr_en) idle_thr_d = pwdata[7:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_cap_q <= srrt_pkg::PEER_CAP_RST;
      own_cap_q  <= srrt_pkg::OWN_CAP_RST;
      idle_thr_q <= srrt_pkg::IDLE_THR_RST;
    end else begin
      peer_cap_q <= peer_cap_d;
      own_cap_q  <= own_cap_d;
      idle_thr_q <= idle_thr_d;
    end
  end

  // missing numbers that fit one packet under the smaller capacity
  assign cap = (peer_cap_q < own_cap_q) ? peer_cap_q : own_cap_q;

  always_comb begin
    cfg_o.idle_thr = idle_thr_q;
    if (cap < srrt_pkg::HDR_BYTES + srrt_pkg::ENTRY_BYTES) begin
      cfg_o.pkt_entries = '0;
    end else begin
      cfg_o.pkt_entries = srrt_pkg::EntW'((cap - srrt_pkg::HDR_BYTES) / srrt_pkg::ENTRY_BYTES);
    end
  end

endmodule

FILE: rtl/srrt_ctrl.sv
module srrt_ctrl #(
  parameter int unsigned PARTS = 32,
  parameter int unsigned CntW  = 6,
  parameter int unsigned IdxW  = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        part_total_i,
  input  logic [15:0]        part_number_i,
  input  logic               has_payload_i,
  input  srrt_pkg::cfg_t     cfg_i,
  input  logic               can_emit_i,
  output logic               emit_o,
  output srrt_pkg::res_t     res_o,
  output logic               mem_we_o,
  output logic [IdxW-1:0]    mem_waddr_o,
  output logic               mem_wdata_o,
  output logic               mem_re_o,
  output logic [IdxW-1:0]    mem_raddr_o,
  input  logic               mem_rdata_i
);

  srrt_pkg::state_e state_q, state_d;

  logic [1:0]               req_q, req_d;
  logic [CntW-1:0]          pc_q, pc_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          pos_q, pos_d;
  logic [15:0]              seq_q, seq_d;
  logic [7:0]               idle_q, idle_d;
  logic                     meta_q, meta_d;
  logic                     link_q, link_d;
  logic                     done_q, done_d;
  logic [srrt_pkg::EntW-1:0] found_q, found_d;
  logic [5:0]               pend_q, pend_d;

  logic [15:0] num_m1;
  logic        reject;
  logic        adv;
  logic [7:0]  idle_inc;
  logic        round_end;

  assign num_m1   = part_number_i - 16'd1;
  assign reject   = (part_number_i == 16'd0) || (part_number_i > 16'(pc_q)) || !meta_q;
  assign adv      = link_q && meta_q && (pc_q != '0);
  assign idle_inc = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
  assign round_end = adv && (idle_inc >= cfg_i.idle_thr);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    seq_d       = seq_q;
    idle_d      = idle_q;
    meta_d      = meta_q;
    link_d      = link_q;
    done_d      = done_q;
    found_d     = found_q;
    pend_d      = pend_q;
    in_ready_o  = (state_q == srrt_pkg::ST_IDLE);
    emit_o      = 1'b0;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q[IdxW-1:0];
    mem_wdata_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = pos_q[IdxW-1:0];

    case (state_q)
      srrt_pkg::ST_IDLE: begin
        if (in_valid_i && !done_q) begin
          req_d = req_type_i;
          if (req_type_i != srrt_pkg::REQ_POLL) idle_d = '0;
          case (req_type_i)
            srrt_pkg::REQ_META: begin
              pc_d    = (part_total_i > 16'(PARTS)) ? CntW'(PARTS)
                                                     : part_total_i[CntW-1:0];
              cnt_d   = '0;
              meta_d  = 1'b1;
              seq_d   = 16'd1;
              pos_d   = '0;
              state_d = srrt_pkg::ST_CLEAR;
            end
            srrt_pkg::REQ_DATA: begin
              if (!reject) begin
                link_d = 1'b1;
                if (has_payload_i) begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = num_m1[IdxW-1:0];
                  pos_d       = num_m1[CntW-1:0];
                  state_d     = srrt_pkg::ST_MARK;
                end
              end
            end
            default: state_d = srrt_pkg::ST_ADV;
          endcase
        end
      end

      // read-modify-write of the part bit, counting only fresh arrivals
      srrt_pkg::ST_MARK: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = 1'b1;
        if (!mem_rdata_i) cnt_d = cnt_q + CntW'(1);
        state_d = srrt_pkg::ST_ADV;
      end

      srrt_pkg::ST_CLEAR: begin
        if (pos_q == pc_q) begin
          state_d = srrt_pkg::ST_ADV;
        end else begin
          mem_we_o = 1'b1;
          pos_d    = pos_q + CntW'(1);
        end
      end

      srrt_pkg::ST_ADV: begin
        if (req_q != srrt_pkg::REQ_META || can_emit_i) begin
          if (req_q == srrt_pkg::REQ_META) begin
            emit_o     = 1'b1;
            res_o.kind = srrt_pkg::KIND_ACK;
            res_o.eop  = 1'b1;
            res_o.last = !round_end;
          end
          if (adv) idle_d = round_end ? 8'd0 : idle_inc;
          if (!round_end) begin
            state_d = srrt_pkg::ST_IDLE;
          end else if (cnt_q == pc_q) begin
            state_d = srrt_pkg::ST_CMPL;
          end else begin
            pos_d   = '0;
            found_d = '0;
            state_d = srrt_pkg::ST_SCAN_CHK;
          end
        end
      end

      srrt_pkg::ST_CMPL: begin
        if (can_emit_i) begin
          emit_o     = 1'b1;
          res_o.kind = srrt_pkg::KIND_CMPL;
          res_o.seq  = seq_q;
          res_o.eop  = 1'b1;
          res_o.last = 1'b1;
          seq_d      = seq_q + 16'd1;
          done_d     = 1'b1;
          state_d    = srrt_pkg::ST_IDLE;
        end
      end

      // closes packets; the held entry gets its end-of-packet flag here
      srrt_pkg::ST_SCAN_CHK: begin
        if (pos_q == pc_q || found_q == cfg_i.pkt_entries) begin
          if (can_emit_i) begin
            emit_o    = 1'b1;
            res_o.seq = seq_q;
            res_o.eop = 1'b1;
            seq_d     = seq_q + 16'd1;
            found_d   = '0;
            if (found_q == '0) begin
              res_o.kind = srrt_pkg::KIND_EMPTY;
              res_o.last = 1'b1;
              state_d    = srrt_pkg::ST_IDLE;
            end else begin
              res_o.kind = srrt_pkg::KIND_MISS;
              res_o.miss = pend_q;
              res_o.last = (pos_q == pc_q);
              if (pos_q == pc_q) state_d = srrt_pkg::ST_IDLE;
            end
          end
        end else begin
          mem_re_o = 1'b1;
          state_d  = srrt_pkg::ST_SCAN_EV;
        end
      end

      srrt_pkg::ST_SCAN_EV: begin
        if (mem_rdata_i) begin
          pos_d   = pos_q + CntW'(1);
          state_d = srrt_pkg::ST_SCAN_CHK;
        end else if (found_q == '0 || can_emit_i) begin
          if (found_q != '0) begin
            emit_o     = 1'b1;
            res_o.kind = srrt_pkg::KIND_MISS;
            res_o.seq  = seq_q;
            res_o.miss = pend_q;
          end
          pend_d  = 6'(pos_q) + 6'd1;
          found_d = found_q + srrt_pkg::EntW'(1);
          pos_d   = pos_q + CntW'(1);
          state_d = srrt_pkg::ST_SCAN_CHK;
        end
      end

      default: state_d = srrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srrt_pkg::ST_IDLE;
      req_q   <= srrt_pkg::REQ_POLL;
      pc_q    <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      seq_q   <= 16'd1;
      idle_q  <= '0;
      meta_q  <= 1'b0;
      link_q  <= 1'b0;
      done_q  <= 1'b0;
      found_q <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      seq_q   <= seq_d;
      idle_q  <= idle_d;
      meta_q  <= meta_d;
      link_q  <= link_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pc_q)
    else $error("received count above part count");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> can_emit_i)
    else $error("result issued while output stage full");

  a_silent_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !emit_o && !mem_we_o)
    else $error("activity after completion");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srrt_pkg::ST_SCAN_CHK || state_q == srrt_pkg::ST_SCAN_EV)
      |-> found_q <= cfg_i.pkt_entries && pos_q <= pc_q)
    else $error("scan ran past packet or part count");

  a_mark_then_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == srrt_pkg::ST_MARK |=> state_q == srrt_pkg::ST_ADV)
    else $error("mark not followed by idle update");

endmodule

FILE: rtl/selective_repeat_receive_tracker_unit.sv
// Receive-side tracker for a selective-repeat transfer. Each accepted item is
// handled on its own by a sequencer around one part bitmap held in a
// synchronous memory: an idle poll or unknown message goes straight to the
// update step, a data part with payload is read, marked and then updated,
// metadata first zeroes the bitmap entries of the new transfer one per cycle,
// and a round end completes the transfer if every part is in, else scans the
// parts, one memory read each, and closes control packets. A stalled result
// consumer holds the sequencer only when a further result has to be issued.
// Results come out of a one-entry output register; kind, packet_sequence,
// missing_part, end_of_packet and last describe one line of a control packet.
module selective_repeat_receive_tracker_unit #(
  parameter int unsigned PARTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] part_total_i,
  input  logic [15:0] part_number_i,
  input  logic        has_payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] packet_sequence_o,
  output logic [5:0]  missing_part_o,
  output logic        end_of_packet_o,
  output logic        last_o
);

  localparam int unsigned CntW = $clog2(PARTS + 1);
  localparam int unsigned IdxW = (PARTS > 1) ? $clog2(PARTS) : 1;

  srrt_pkg::cfg_t cfg;
  srrt_pkg::res_t res;
  srrt_pkg::res_t out_q;
  logic           out_valid_q, out_valid_d;
  logic           can_emit;
  logic           emit;
  logic           mem_we, mem_wdata, mem_re, mem_rdata;
  logic [IdxW-1:0] mem_waddr, mem_raddr;

  srrt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srrt_map_ram #(
    .Depth (PARTS),
    .AddrW (IdxW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  srrt_ctrl #(
    .PARTS (PARTS),
    .CntW  (CntW),
    .IdxW  (IdxW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .part_total_i  (part_total_i),
    .part_number_i (part_number_i),
    .has_payload_i (has_payload_i),
    .cfg_i         (cfg),
    .can_emit_i    (can_emit),
    .emit_o        (emit),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // output register frees up in the same cycle its item is taken
  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign packet_sequence_o = out_q.seq;
  assign missing_part_o    = out_q.miss;
  assign end_of_packet_o   = out_q.eop;
  assign last_o            = out_q.last;

endmodule
